>>> rtl/core/ppubg_pkg.sv
// Package for the PPU background tile pipeline: payload and control types,
// fetch phase codes, register indexes and address constants.
// No dependencies.
package ppubg_pkg;

    localparam int unsigned DOT_W   = 9;
    localparam int unsigned VADDR_W = 15;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned ADDR_W  = 14;
    localparam int unsigned PAL_W   = 4;
    localparam int unsigned FINE_W  = 3;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 3;

    localparam int unsigned DEF_CFG_IDX_W  = CFG_IDX_W;
    localparam int unsigned DEF_CFG_DATA_W = CFG_DATA_W;

    typedef enum logic [2:0] {
        PH_HI_READ  = 3'd0,
        PH_NT_ADDR  = 3'd1,
        PH_NT_READ  = 3'd2,
        PH_AT_ADDR  = 3'd3,
        PH_AT_READ  = 3'd4,
        PH_LO_ADDR  = 3'd5,
        PH_LO_READ  = 3'd6,
        PH_HI_ADDR  = 3'd7
    } t_phase;

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FINE_X       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOW_LEFT    = 2'd2;

    localparam logic [ADDR_W-1:0] NT_BASE      = 14'h2000;
    localparam logic [ADDR_W-1:0] NT_MASK      = 14'h0FFF;
    localparam logic [ADDR_W-1:0] AT_KEEP_MASK = 14'h2C00;
    localparam logic [ADDR_W-1:0] AT_OFFSET    = 14'h03C0;
    localparam logic [ADDR_W-1:0] PT_STEP      = 14'h0008;
    localparam logic [DOT_W-1:0]  LEFT_LIMIT   = 9'd9;

    typedef struct packed {
        logic [DOT_W-1:0]   dot_cycle;
        logic [VADDR_W-1:0] vram_address;
        logic [BYTE_W-1:0]  read_byte;
        logic               draw_enable;
    } t_dot_item;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [1:0]        attribute;
        logic [BYTE_W-1:0] pattern_low;
    } t_tile_latch;

    typedef struct packed {
        logic              reload;
        logic [BYTE_W-1:0] pattern_low;
        logic [BYTE_W-1:0] pattern_high;
        logic [1:0]        attribute;
    } t_shift_load;

    typedef struct packed {
        logic [PAL_W-1:0]  palette_index;
        logic              pixel_opaque;
        logic              pixel_valid;
        logic              coarse_x_step;
    } t_pixel_result;

endpackage

>>> rtl/core/ppubg_if.sv
// Channel interfaces of the PPU background tile pipeline: dot input and
// pixel output, each with valid/ready. Depends on ppubg_pkg.
interface ppubg_dot_if;
    logic                            valid;
    logic                            ready;
    logic [ppubg_pkg::DOT_W-1:0]     dot_cycle;
    logic [ppubg_pkg::VADDR_W-1:0]   vram_address;
    logic [ppubg_pkg::BYTE_W-1:0]    read_byte;
    logic                            draw_enable;

    modport source (output valid, dot_cycle, vram_address, read_byte, draw_enable,
                    input ready);
    modport sink   (input valid, dot_cycle, vram_address, read_byte, draw_enable,
                    output ready);
endinterface

interface ppubg_pixel_if;
    logic                            valid;
    logic                            ready;
    logic [ppubg_pkg::ADDR_W-1:0]    mem_address;
    logic [ppubg_pkg::PAL_W-1:0]     palette_index;
    logic                            pixel_opaque;
    logic                            pixel_valid;
    logic                            coarse_x_step;

    modport source (output valid, mem_address, palette_index, pixel_opaque,
                    pixel_valid, coarse_x_step, input ready);
    modport sink   (input valid, mem_address, palette_index, pixel_opaque,
                    pixel_valid, coarse_x_step, output ready);
endinterface

>>> rtl/core/ppubg_fetch.sv
// Fetch sequencer: address latch and the tile, attribute and pattern-low
// latches, stepped once per accepted dot. Depends on ppubg_pkg.
module ppubg_fetch (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_advance,
    input  ppubg_pkg::t_dot_item    i_dot,
    input  logic                    i_pattern_base,
    output ppubg_pkg::t_tile_latch  o_latch
);

    logic [ppubg_pkg::ADDR_W-1:0] r_address;
    logic [ppubg_pkg::ADDR_W-1:0] n_address;
    logic [ppubg_pkg::BYTE_W-1:0] r_tile;
    logic [ppubg_pkg::BYTE_W-1:0] n_tile;
    logic [1:0]                   r_attribute;
    logic [1:0]                   n_attribute;
    logic [ppubg_pkg::BYTE_W-1:0] r_pattern_low;
    logic [ppubg_pkg::BYTE_W-1:0] n_pattern_low;
    ppubg_pkg::t_phase            w_phase;
    logic [1:0]                   w_quad;
    logic [5:0]                   w_at_cell;

    assign w_phase   = ppubg_pkg::t_phase'(i_dot.dot_cycle[2:0]);
    assign w_quad    = {i_dot.vram_address[6], i_dot.vram_address[1]};
    assign w_at_cell = {i_dot.vram_address[9:7], i_dot.vram_address[4:2]};

    always_comb begin
        n_address     = r_address;
        n_tile        = r_tile;
        n_attribute   = r_attribute;
        n_pattern_low = r_pattern_low;
        unique case (w_phase)
            ppubg_pkg::PH_NT_ADDR: begin
                n_address = ppubg_pkg::NT_BASE
                          | (i_dot.vram_address[ppubg_pkg::ADDR_W-1:0] & ppubg_pkg::NT_MASK);
            end
            ppubg_pkg::PH_NT_READ: begin
                n_tile = i_dot.read_byte;
            end
            ppubg_pkg::PH_AT_ADDR: begin
                n_address = (r_address & ppubg_pkg::AT_KEEP_MASK) + ppubg_pkg::AT_OFFSET
                          + {8'd0, w_at_cell};
            end
            ppubg_pkg::PH_AT_READ: begin
                unique case (w_quad)
                    2'd0: n_attribute = i_dot.read_byte[1:0];
                    2'd1: n_attribute = i_dot.read_byte[3:2];
                    2'd2: n_attribute = i_dot.read_byte[5:4];
                    default: n_attribute = i_dot.read_byte[7:6];
                endcase
            end
            ppubg_pkg::PH_LO_ADDR: begin
                n_address = {1'b0, i_pattern_base, r_tile, 1'b0,
                             i_dot.vram_address[14:12]};
            end
            ppubg_pkg::PH_LO_READ: begin
                n_pattern_low = i_dot.read_byte;
            end
            ppubg_pkg::PH_HI_ADDR: begin
                n_address = r_address + ppubg_pkg::PT_STEP;
            end
            default: begin
                // pattern-high byte goes straight to the shifters
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_address     <= '0;
            r_tile        <= '0;
            r_attribute   <= '0;
            r_pattern_low <= '0;
        end else if (i_advance) begin
            r_address     <= n_address;
            r_tile        <= n_tile;
            r_attribute   <= n_attribute;
            r_pattern_low <= n_pattern_low;
        end
    end

    assign o_latch.address     = r_address;
    assign o_latch.attribute   = r_attribute;
    assign o_latch.pattern_low = r_pattern_low;

endmodule

>>> rtl/core/ppubg_shift.sv
// Pattern and attribute shifters with fine-x pixel pick.
// Depends on ppubg_pkg.
module ppubg_shift (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_advance,
    input  ppubg_pkg::t_shift_load          i_load,
    input  logic [ppubg_pkg::FINE_W-1:0]    i_fine_x,
    output logic [ppubg_pkg::PAL_W-1:0]     o_pixel
);

    logic [15:0] r_pat_lo;
    logic [15:0] n_pat_lo;
    logic [15:0] r_pat_hi;
    logic [15:0] n_pat_hi;
    logic [7:0]  r_attr_lo;
    logic [7:0]  r_attr_hi;
    logic [1:0]  r_feed;
    logic [7:0]  w_lo_top;
    logic [7:0]  w_hi_top;
    logic [2:0]  w_sel;

    assign w_sel    = ~i_fine_x;
    assign w_lo_top = r_pat_lo[15:8];
    assign w_hi_top = r_pat_hi[15:8];
    assign o_pixel  = {r_attr_hi[w_sel], r_attr_lo[w_sel], w_hi_top[w_sel], w_lo_top[w_sel]};

    always_comb begin
        if (i_load.reload) begin
            n_pat_lo = {r_pat_lo[14:7], i_load.pattern_low};
            n_pat_hi = {r_pat_hi[14:7], i_load.pattern_high};
        end else begin
            n_pat_lo = {r_pat_lo[14:0], 1'b0};
            n_pat_hi = {r_pat_hi[14:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo  <= '0;
            r_pat_hi  <= '0;
            r_attr_lo <= '0;
            r_attr_hi <= '0;
            r_feed    <= '0;
        end else if (i_advance) begin
            r_pat_lo  <= n_pat_lo;
            r_pat_hi  <= n_pat_hi;
            r_attr_lo <= {r_attr_lo[6:0], r_feed[0]};
            r_attr_hi <= {r_attr_hi[6:0], r_feed[1]};
            if (i_load.reload) begin
                r_feed <= i_load.attribute;
            end
        end
    end

endmodule

>>> rtl/core/ppu_background_tile_pipeline.sv
// Top level of the PPU background tile pipeline: config registers, result
// register and handshake. Depends on ppubg_pkg, ppubg_if, ppubg_fetch, ppubg_shift.
//
// Channel    Dir  Fields
// i_dot      in   dot_cycle[8:0] vram_address[14:0] read_byte[7:0] draw_enable
// o_pixel    out  mem_address[13:0] palette_index[3:0] pixel_opaque pixel_valid
//                 coarse_x_step
// i_cfg_*    in   we, index[1:0], data[2:0]
//
// One dot per cycle unless o_pixel stalls; a result appears in the cycle after
// its transaction. The single result register sets the rate; i_dot takes a
// new dot whenever that register is empty or being drained in the same cycle.
// Synchronous active-low reset clears all latches, shifters and config.
// A stall on o_pixel holds the result and all state until it is taken.
module ppu_background_tile_pipeline #(
    parameter int unsigned CFG_IDX_W  = ppubg_pkg::DEF_CFG_IDX_W,
    parameter int unsigned CFG_DATA_W = ppubg_pkg::DEF_CFG_DATA_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ppubg_dot_if.sink             i_dot,
    ppubg_pixel_if.source         o_pixel,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic                            r_pattern_base;
    logic [ppubg_pkg::FINE_W-1:0]    r_fine_x;
    logic                            r_show_left;
    logic                            r_valid;
    ppubg_pkg::t_pixel_result        r_result;
    ppubg_pkg::t_pixel_result        n_result;
    logic                            w_accept;
    logic                            w_shown;
    logic [ppubg_pkg::PAL_W-1:0]     w_pixel;
    logic                            w_phase_hi;
    ppubg_pkg::t_dot_item            w_dot;
    ppubg_pkg::t_tile_latch          w_latch;
    ppubg_pkg::t_shift_load          w_load;

    assign i_dot.ready = !r_valid || o_pixel.ready;
    assign w_accept    = i_dot.valid && i_dot.ready;

    assign w_dot.dot_cycle    = i_dot.dot_cycle;
    assign w_dot.vram_address = i_dot.vram_address;
    assign w_dot.read_byte    = i_dot.read_byte;
    assign w_dot.draw_enable  = i_dot.draw_enable;

    assign w_phase_hi = (ppubg_pkg::t_phase'(i_dot.dot_cycle[2:0]) == ppubg_pkg::PH_HI_READ);

    ppubg_fetch u_fetch (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_advance      (w_accept),
        .i_dot          (w_dot),
        .i_pattern_base (r_pattern_base),
        .o_latch        (w_latch)
    );

    assign w_load.reload       = w_phase_hi;
    assign w_load.pattern_low  = w_latch.pattern_low;
    assign w_load.pattern_high = i_dot.read_byte;
    assign w_load.attribute    = w_latch.attribute;

    ppubg_shift u_shift (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_advance(w_accept),
        .i_load   (w_load),
        .i_fine_x (r_fine_x),
        .o_pixel  (w_pixel)
    );

    assign w_shown = i_dot.draw_enable
                  && !((i_dot.dot_cycle < ppubg_pkg::LEFT_LIMIT) && !r_show_left);

    always_comb begin
        n_result.palette_index = w_shown ? w_pixel : '0;
        n_result.pixel_opaque  = w_shown && (w_pixel[1:0] != 2'd0);
        n_result.pixel_valid   = i_dot.draw_enable;
        n_result.coarse_x_step = w_phase_hi;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_base <= 1'b0;
            r_fine_x       <= '0;
            r_show_left    <= 1'b0;
        end else if (i_cfg_we) begin
            priority if (i_cfg_index == CFG_IDX_W'(ppubg_pkg::CFG_PATTERN_BASE)) begin
                r_pattern_base <= i_cfg_data[0];
            end else if (i_cfg_index == CFG_IDX_W'(ppubg_pkg::CFG_FINE_X)) begin
                r_fine_x <= i_cfg_data[ppubg_pkg::FINE_W-1:0];
            end else if (i_cfg_index == CFG_IDX_W'(ppubg_pkg::CFG_SHOW_LEFT)) begin
                r_show_left <= i_cfg_data[0];
            end else begin
                // unused index
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (o_pixel.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_result <= n_result;
        end
    end

    // address latch only moves on a transaction, so it tracks the held result
    assign o_pixel.valid         = r_valid;
    assign o_pixel.mem_address   = w_latch.address;
    assign o_pixel.palette_index = r_result.palette_index;
    assign o_pixel.pixel_opaque  = r_result.pixel_opaque;
    assign o_pixel.pixel_valid   = r_result.pixel_valid;
    assign o_pixel.coarse_x_step = r_result.coarse_x_step;

`ifndef SYNTHESIS
    a_step_on_high_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_phase_hi) |=> (o_pixel.valid && o_pixel.coarse_x_step))
        else $error("coarse x step missing after pattern-high fetch");

    a_opaque_has_pattern: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pixel.valid && o_pixel.pixel_opaque) |->
            (o_pixel.pixel_valid && (o_pixel.palette_index[1:0] != 2'd0)))
        else $error("opaque pixel without pattern bits");

    a_undrawn_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pixel.valid && !o_pixel.pixel_valid) |->
            ((o_pixel.palette_index == '0) && !o_pixel.pixel_opaque))
        else $error("undrawn dot carries a pixel");

    a_high_addr_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_dot.dot_cycle[2:0] == ppubg_pkg::PH_HI_ADDR)) |=>
            (o_pixel.mem_address
                == ppubg_pkg::ADDR_W'($past(o_pixel.mem_address) + ppubg_pkg::PT_STEP)))
        else $error("pattern-high address not offset from pattern-low");

    a_hold_without_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> $stable(o_pixel.mem_address))
        else $error("address latch moved without a transaction");
`endif

endmodule
